@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the drive checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define CHK_IMPLY(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, held off during reset
`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/evpmd_pkg.sv @@
// ----------------------------------------------------------------------------
// evpmd_pkg
// Widths, field offsets, register indexes and constants of the motor drive.
// ----------------------------------------------------------------------------
package evpmd_pkg;

	// default width of distances, velocities, errors and the drive value
	localparam int VALUE_WIDTH_DEF = 32;

	// gain and scale registers, and the shared multiplier operand width
	localparam int GAIN_W = 24;
	localparam logic [GAIN_W-1:0] DPP_RESET = 24'd91264;

	// field widths
	localparam int ENC_W   = 16;
	localparam int ACCEL_W = 16;
	localparam int FIELD_W = 32;
	localparam int CMP_W   = 14;

	// input tdata: encoder_count, drive_enable, move_distance,
	// slowdown_distance, cruise_velocity, final_velocity, acceleration
	localparam int ENC_LSB    = 0;
	localparam int EN_BIT     = 16;
	localparam int MDIST_LSB  = 17;
	localparam int SDIST_LSB  = 49;
	localparam int CRUISE_LSB = 81;
	localparam int FINAL_LSB  = 113;
	localparam int ACCEL_LSB  = 145;
	localparam int S_TDATA_W  = 168;

	// output tdata: channel_one, channel_two, travelled, mean
	localparam int M_TDATA_W  = 96;

	// APB address and data widths
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register indexes
	localparam logic [1:0] REG_KP  = 2'd0;
	localparam logic [1:0] REG_KD  = 2'd1;
	localparam logic [1:0] REG_DPP = 2'd2;

	// action codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_MOVE = 1'b1;

	// encoder counts above this read as negative
	localparam logic [ENC_W-1:0] ENC_HALF = 16'd32768;

	// bridge compare top and drive limit (Q.8)
	localparam int PWM_TOP     = 10000;
	localparam int DRIVE_LIMIT = 2560000;

	// ramp step = accel * 32 / 125, via reciprocal 2^22 / 125 rounded up
	localparam int RAMP_RECIP   = 33555;
	localparam int RAMP_SHIFT   = 22;
	localparam int RAMP_DIVISOR = 125;
	localparam int RAMP_STEP_W  = 15;

	// velocity scale
	localparam int VEL_SCALE = 1000;

endpackage

@@ rtl/encoder_velocity_pid_motor_drive.sv @@
// Move command: the result is registered in S_RATE once the output is free.
// Control tick: four chained multiplies through one 24x24 multiplier, each
// over the 24-bit chunks of a VALUE_WIDTH+2 bit operand, precede S_DRIVE,
// which registers the result once the output is free.
// A new request is taken the cycle after the result is registered; a result
// still held by m_tready keeps the sequencer in its posting step.
// arst_n clears all state and config to reset values asynchronously.
// ----------------------------------------------------------------------------
// encoder_velocity_pid_motor_drive
// Encoder odometry, trapezoidal speed ramp and velocity-form PD drive with
// H-bridge compare outputs, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
module encoder_velocity_pid_motor_drive #(
	parameter int VALUE_WIDTH = evpmd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave stream: request in
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [15:0] encoder_count, [16] drive_enable, [48:17] move_distance,
	// [80:49] slowdown_distance, [112:81] cruise_velocity,
	// [144:113] final_velocity, [160:145] acceleration, rest zero
	input  logic [evpmd_pkg::S_TDATA_W-1:0]    s_tdata,
	// [0] action
	input  logic                               s_tuser,
	// master stream: result out
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [13:0] channel_one_compare, [27:14] channel_two_compare,
	// [59:28] travelled_distance, [91:60] mean_velocity, rest zero
	output logic [evpmd_pkg::M_TDATA_W-1:0]    m_tdata,
	// [0] pwm_update
	output logic                               m_tuser,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [evpmd_pkg::PADDR_W-1:0]      paddr,
	input  logic [evpmd_pkg::PDATA_W-1:0]      pwdata,
	output logic [evpmd_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready
);

	localparam int W      = VALUE_WIDTH;
	localparam int GW     = evpmd_pkg::GAIN_W;
	localparam int MAG_W  = W + 2;
	localparam int NCH    = (MAG_W + GW - 1) / GW;
	localparam int MAGW   = NCH * GW;
	localparam int RACC_W = MAGW + GW;
	localparam int RQ_W   = RACC_W - 16;
	localparam int CNT_W  = $clog2(NCH + 1);
	localparam int SAT_W  = (W + 3 > 33) ? W + 3 : 33;
	localparam int O_W    = (W > 32) ? W : 32;
	localparam int RSW    = evpmd_pkg::RAMP_STEP_W;
	localparam int RY_W   = evpmd_pkg::ACCEL_W + 5;
	localparam int RP_W   = RY_W + 16;
	localparam int CW     = evpmd_pkg::CMP_W;

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RATE    = 4'd1;
	localparam logic [3:0] S_MUL_A   = 4'd2;
	localparam logic [3:0] S_MUL_B   = 4'd3;
	localparam logic [3:0] S_MUL_END = 4'd4;
	localparam logic [3:0] S_DIST    = 4'd5;
	localparam logic [3:0] S_VEL     = 4'd6;
	localparam logic [3:0] S_BRAKE   = 4'd7;
	localparam logic [3:0] S_RAMP    = 4'd8;
	localparam logic [3:0] S_ERR     = 4'd9;
	localparam logic [3:0] S_PLOAD   = 4'd10;
	localparam logic [3:0] S_P       = 4'd11;
	localparam logic [3:0] S_D       = 4'd12;
	localparam logic [3:0] S_DRIVE   = 4'd13;

	// multiply jobs
	localparam logic [1:0] JOB_DIST = 2'd0;
	localparam logic [1:0] JOB_VEL  = 2'd1;
	localparam logic [1:0] JOB_P    = 2'd2;
	localparam logic [1:0] JOB_D    = 2'd3;

	// saturate a wide signed value to W bits
	function automatic logic signed [W-1:0] sat_w(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = $signed({{(SAT_W-W+1){1'b0}}, {(W-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[W-1:0];
		end else if (v < lo) begin
			return lo[W-1:0];
		end
		return v[W-1:0];
	endfunction

	// saturate a W-bit value to the 32-bit field range
	function automatic logic [31:0] sat32(input logic signed [W-1:0] v);
		logic signed [O_W-1:0] x;
		x = O_W'(v);
		if (x > O_W'(32'sh7FFF_FFFF)) begin
			return 32'h7FFF_FFFF;
		end else if (x < O_W'(32'sh8000_0000)) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

	logic [3:0] state_q;

	// configuration
	logic [GW-1:0] kp_q;
	logic [GW-1:0] kd_q;
	logic [GW-1:0] dpp_q;

	// drive state
	logic signed [W-1:0] dsum_q;
	logic signed [W-1:0] prev_vel_q;
	logic signed [W-1:0] plan_q;
	logic signed [W-1:0] goal_vel_q;
	logic signed [W-1:0] goal_dist_q;
	logic signed [W-1:0] brake_dist_q;
	logic signed [W-1:0] brake_vel_q;
	logic [RSW-1:0]      ramp_step_q;
	logic                armed_q;
	logic signed [W-1:0] e_q [4];
	logic signed [W-1:0] acc_q;

	// per-request working registers
	logic [16:0]         q_mag_q;
	logic                q_neg_q;
	logic                en_q;
	logic signed [W-1:0] mean_q;
	logic signed [W-1:0] p_q;
	logic [RY_W-1:0]     rate_y_q;
	logic [RSW-1:0]      q0_q;

	// shared multiplier
	logic [MAGW-1:0]     mag_q;
	logic                neg_q;
	logic [GW-1:0]       gain_q;
	logic [2*GW-1:0]     prod_q;
	logic [RACC_W-1:0]   racc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [1:0]          job_q;
	logic signed [W-1:0] res_q;

	// output register
	logic                out_vld_q;
	logic                out_pwm_q;
	logic [CW-1:0]       out_ch1_q;
	logic [CW-1:0]       out_ch2_q;
	logic [31:0]         out_trav_q;
	logic [31:0]         out_mean_q;

	logic out_free;
	logic out_post;
	logic cfg_wr;

	// combinational datapath terms
	logic [15:0]         enc_cnt;
	logic                enc_neg;
	logic [16:0]         enc_mag;
	logic [RY_W-1:0]     rate_y;
	logic [RP_W-1:0]     rate_p;
	logic [21:0]         rate_chk;
	logic [26:0]         vel_mag;
	logic [RQ_W-1:0]     rq;
	logic [RQ_W-1:0]     rlim;
	logic [RQ_W-1:0]     rsat;
	logic [W-1:0]        rw;
	logic signed [W:0]   vsum;
	logic signed [W:0]   vadj;
	logic signed [W:0]   gdiff;
	logic [W:0]          remain;
	logic                brake_hit;
	logic signed [W:0]   stepx;
	logic signed [W:0]   ramp_up;
	logic signed [W:0]   ramp_dn;
	logic [W-1:0]        emag;
	logic signed [W+2:0] d03;
	logic signed [W+2:0] d12;
	logic signed [W+2:0] combo;
	logic [W+2:0]        cmag;
	logic signed [W-1:0] dlim;
	logic signed [W-1:0] acc_pos;
	logic signed [W-1:0] acc_neg;
	logic signed [W-1:0] acc_negm;
	logic                acc_gt0;
	logic [CW-1:0]       duty;
	logic [CW-1:0]       pwm_top;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || m_tready;
	assign out_post = out_free && ((state_q == S_RATE) || (state_q == S_DRIVE));
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_pwm_q;
	assign m_tdata  = {4'b0, out_mean_q, out_trav_q, out_ch2_q, out_ch1_q};
	assign pwm_top  = CW'(evpmd_pkg::PWM_TOP);

	// register read-back
	always_comb begin
		unique case (paddr[3:2])
			evpmd_pkg::REG_KP:  prdata = {8'b0, kp_q};
			evpmd_pkg::REG_KD:  prdata = {8'b0, kd_q};
			evpmd_pkg::REG_DPP: prdata = {8'b0, dpp_q};
			default:            prdata = '0;
		endcase
	end

	// datapath terms used by the sequencer
	always_comb begin
		// raw encoder count folded to sign and magnitude
		enc_cnt = s_tdata[evpmd_pkg::ENC_LSB +: evpmd_pkg::ENC_W];
		enc_neg = enc_cnt > evpmd_pkg::ENC_HALF;
		enc_mag = enc_neg ? (17'd65536 - {1'b0, enc_cnt}) : {1'b0, enc_cnt};

		// ramp step estimate and its correction
		rate_y   = {s_tdata[evpmd_pkg::ACCEL_LSB +: evpmd_pkg::ACCEL_W], 5'b0};
		rate_p   = RP_W'(rate_y) * RP_W'(evpmd_pkg::RAMP_RECIP);
		rate_chk = 22'(q0_q) * 22'(evpmd_pkg::RAMP_DIVISOR);

		// velocity operand: |count| * 1000
		vel_mag = 27'(q_mag_q) * 27'(evpmd_pkg::VEL_SCALE);

		// multiplier result: drop 16 fraction bits, saturate, restore sign
		rq   = racc_q[RACC_W-1:16];
		rlim = {{(RQ_W-W+1){1'b0}}, {(W-1){1'b1}}} + {{(RQ_W-1){1'b0}}, neg_q};
		rsat = (rq > rlim) ? rlim : rq;
		rw   = rsat[W-1:0];

		// mean of two velocities, rounded toward zero
		vsum = (W+1)'(res_q) + (W+1)'(prev_vel_q);
		vadj = vsum + $signed({{W{1'b0}}, vsum[W]});

		// remaining distance against the slowdown point
		gdiff     = (W+1)'(goal_dist_q) - (W+1)'(dsum_q);
		remain    = gdiff[W] ? (W+1)'(-gdiff) : gdiff;
		brake_hit = !brake_dist_q[W-1] && ({1'b0, brake_dist_q} >= remain);

		// ramp candidates
		stepx   = $signed({{(W+1-RSW){1'b0}}, ramp_step_q});
		ramp_up = (W+1)'(plan_q) + stepx;
		ramp_dn = (W+1)'(plan_q) - stepx;

		// PD operands
		emag  = e_q[0][W-1] ? W'(-e_q[0]) : e_q[0];
		d03   = (W+3)'(e_q[0]) - (W+3)'(e_q[3]);
		d12   = (W+3)'(e_q[1]) - (W+3)'(e_q[2]);
		combo = d03 + d12 + (d12 <<< 1);
		cmag  = combo[W+2] ? (W+3)'(-combo) : combo;

		// drive clamp and duty
		dlim     = W'(evpmd_pkg::DRIVE_LIMIT);
		acc_gt0  = !acc_q[W-1] && (acc_q != '0);
		acc_pos  = (acc_q > dlim) ? dlim : acc_q;
		acc_neg  = (acc_q < -dlim) ? -dlim : acc_q;
		acc_negm = -acc_neg;
		duty     = acc_gt0 ? acc_pos[21:8] : acc_negm[21:8];
	end

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kp_q         <= '0;
			kd_q         <= '0;
			dpp_q        <= evpmd_pkg::DPP_RESET;
			dsum_q       <= '0;
			prev_vel_q   <= '0;
			plan_q       <= '0;
			goal_vel_q   <= '0;
			goal_dist_q  <= '0;
			brake_dist_q <= '0;
			brake_vel_q  <= '0;
			ramp_step_q  <= '0;
			armed_q      <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				e_q[i] <= '0;
			end
			acc_q        <= '0;
			q_mag_q      <= '0;
			q_neg_q      <= 1'b0;
			en_q         <= 1'b0;
			mean_q       <= '0;
			p_q          <= '0;
			rate_y_q     <= '0;
			q0_q         <= '0;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			gain_q       <= '0;
			prod_q       <= '0;
			racc_q       <= '0;
			cnt_q        <= '0;
			job_q        <= JOB_DIST;
			res_q        <= '0;
			out_vld_q    <= 1'b0;
			out_pwm_q    <= 1'b0;
			out_ch1_q    <= '0;
			out_ch2_q    <= '0;
			out_trav_q   <= '0;
			out_mean_q   <= '0;
		end else begin
			// write configuration
			if (cfg_wr) begin
				unique case (paddr[3:2])
					evpmd_pkg::REG_KP:  kp_q  <= pwdata[GW-1:0];
					evpmd_pkg::REG_KD:  kd_q  <= pwdata[GW-1:0];
					evpmd_pkg::REG_DPP: dpp_q <= pwdata[GW-1:0];
					default: ;
				endcase
			end

			// drop the result once taken, unless a new one replaces it
			if (m_tready && !out_post) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == evpmd_pkg::ACT_MOVE) begin
							// load move registers, start ramp step
							goal_dist_q  <= sat_w(SAT_W'($signed(
								s_tdata[evpmd_pkg::MDIST_LSB +: evpmd_pkg::FIELD_W])));
							brake_dist_q <= sat_w(SAT_W'($signed(
								s_tdata[evpmd_pkg::SDIST_LSB +: evpmd_pkg::FIELD_W])));
							goal_vel_q   <= sat_w(SAT_W'($signed(
								s_tdata[evpmd_pkg::CRUISE_LSB +: evpmd_pkg::FIELD_W])));
							brake_vel_q  <= sat_w(SAT_W'($signed(
								s_tdata[evpmd_pkg::FINAL_LSB +: evpmd_pkg::FIELD_W])));
							armed_q      <= 1'b1;
							rate_y_q     <= rate_y;
							q0_q         <= rate_p[RP_W-1 -: RSW];
							state_q      <= S_RATE;
						end else begin
							// tick: start tick distance multiply
							q_mag_q <= enc_mag;
							q_neg_q <= enc_neg;
							en_q    <= s_tdata[evpmd_pkg::EN_BIT];
							mag_q   <= MAGW'(enc_mag);
							neg_q   <= enc_neg;
							gain_q  <= dpp_q;
							racc_q  <= '0;
							cnt_q   <= CNT_W'(NCH);
							job_q   <= JOB_DIST;
							state_q <= S_MUL_A;
						end
					end
				end

				S_RATE: begin
					// correct ramp step, post move result
					if (out_free) begin
						ramp_step_q <= (rate_chk > 22'(rate_y_q)) ? q0_q - RSW'(1) : q0_q;
						out_vld_q   <= 1'b1;
						out_pwm_q   <= 1'b0;
						out_ch1_q   <= '0;
						out_ch2_q   <= '0;
						out_trav_q  <= sat32(dsum_q);
						out_mean_q  <= '0;
						state_q     <= S_IDLE;
					end
				end

				S_MUL_A: begin
					// multiply the top chunk
					prod_q  <= mag_q[MAGW-1 -: GW] * gain_q;
					mag_q   <= mag_q << GW;
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_MUL_B;
				end

				S_MUL_B: begin
					// shift in the partial product
					racc_q  <= (racc_q << GW) + RACC_W'(prod_q);
					state_q <= (cnt_q == '0) ? S_MUL_END : S_MUL_A;
				end

				S_MUL_END: begin
					res_q <= neg_q ? $signed(-rw) : $signed(rw);
					unique case (job_q)
						JOB_DIST: state_q <= S_DIST;
						JOB_VEL:  state_q <= S_VEL;
						JOB_P:    state_q <= S_P;
						JOB_D:    state_q <= S_D;
						default:  state_q <= S_IDLE;
					endcase
				end

				S_DIST: begin
					// advance odometry, start velocity multiply
					dsum_q  <= sat_w(SAT_W'(dsum_q) + SAT_W'(res_q));
					mag_q   <= MAGW'(vel_mag);
					neg_q   <= q_neg_q;
					gain_q  <= dpp_q;
					racc_q  <= '0;
					cnt_q   <= CNT_W'(NCH);
					job_q   <= JOB_VEL;
					state_q <= S_MUL_A;
				end

				S_VEL: begin
					mean_q     <= vadj[W:1];
					prev_vel_q <= res_q;
					state_q    <= S_BRAKE;
				end

				S_BRAKE: begin
					// switch to final velocity at the slowdown point
					if (armed_q && brake_hit) begin
						goal_vel_q <= brake_vel_q;
						armed_q    <= 1'b0;
					end
					state_q <= S_RAMP;
				end

				S_RAMP: begin
					// ramp planned velocity toward the goal
					if (goal_vel_q > plan_q) begin
						plan_q <= (ramp_up > (W+1)'(goal_vel_q)) ? goal_vel_q : ramp_up[W-1:0];
					end else if (goal_vel_q < plan_q) begin
						plan_q <= (ramp_dn < (W+1)'(goal_vel_q)) ? goal_vel_q : ramp_dn[W-1:0];
					end
					state_q <= S_ERR;
				end

				S_ERR: begin
					// shift error history
					e_q[3]  <= e_q[2];
					e_q[2]  <= e_q[1];
					e_q[1]  <= e_q[0];
					e_q[0]  <= sat_w(SAT_W'(plan_q) - SAT_W'(mean_q));
					state_q <= S_PLOAD;
				end

				S_PLOAD: begin
					// start proportional multiply
					mag_q   <= MAGW'(emag);
					neg_q   <= e_q[0][W-1];
					gain_q  <= kp_q;
					racc_q  <= '0;
					cnt_q   <= CNT_W'(NCH);
					job_q   <= JOB_P;
					state_q <= S_MUL_A;
				end

				S_P: begin
					// hold P term, start derivative multiply
					p_q     <= res_q;
					mag_q   <= MAGW'(cmag);
					neg_q   <= combo[W+2];
					gain_q  <= kd_q;
					racc_q  <= '0;
					cnt_q   <= CNT_W'(NCH);
					job_q   <= JOB_D;
					state_q <= S_MUL_A;
				end

				S_D: begin
					acc_q   <= sat_w(SAT_W'(acc_q) + SAT_W'(p_q) + SAT_W'(res_q));
					state_q <= S_DRIVE;
				end

				S_DRIVE: begin
					// clamp drive when enabled, post tick result
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_trav_q <= sat32(dsum_q);
						out_mean_q <= sat32(mean_q);
						if (en_q) begin
							out_pwm_q <= 1'b1;
							if (acc_gt0) begin
								acc_q     <= acc_pos;
								out_ch1_q <= pwm_top - duty;
								out_ch2_q <= pwm_top;
							end else begin
								acc_q     <= acc_neg;
								out_ch1_q <= pwm_top;
								out_ch2_q <= pwm_top - duty;
							end
						end else begin
							out_pwm_q <= 1'b0;
							out_ch1_q <= '0;
							out_ch2_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/evpmd_checker.sv @@
// ----------------------------------------------------------------------------
// evpmd_checker
// Port-level checks of the motor drive, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module evpmd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [evpmd_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	logic [evpmd_pkg::CMP_W-1:0] ch1;
	logic [evpmd_pkg::CMP_W-1:0] ch2;
	logic [evpmd_pkg::CMP_W-1:0] top;

	assign ch1 = m_tdata[evpmd_pkg::CMP_W-1:0];
	assign ch2 = m_tdata[2*evpmd_pkg::CMP_W-1:evpmd_pkg::CMP_W];
	assign top = evpmd_pkg::CMP_W'(evpmd_pkg::PWM_TOP);

	// a stalled result holds
	`CHK_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// one request at a time: busy right after an accept
	`CHK_NEXT(a_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// no compare update: both compares idle at zero
	`CHK_IMPLY(a_idle_cmp, clk, arst_n, m_tvalid && !m_tuser, (ch1 == '0) && (ch2 == '0))

	// compare update: one side at top, other within range
	`CHK_IMPLY(a_bridge, clk, arst_n, m_tvalid && m_tuser, ((ch1 == top) && (ch2 <= top)) || ((ch2 == top) && (ch1 <= top)))

endmodule

bind encoder_velocity_pid_motor_drive evpmd_checker u_evpmd_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// encoder_velocity_pid_motor_drive testbench
// Sends tick and move requests over the input stream and checks every result
// on the output stream against a cycle-free predictor of the odometry, the
// speed ramp and the PD drive. The gain and scale registers are programmed
// over APB between phases and read back.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import evpmd_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int HOLD_AFTER_RESULTS = 350;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;
	localparam longint VAL_MAX = (64'sd1 <<< (VW - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;

	typedef struct packed {
		logic        action;
		logic [15:0] count;
		logic        enable;
		logic [31:0] goal_dist;
		logic [31:0] slow_dist;
		logic [31:0] cruise_vel;
		logic [31:0] final_vel;
		logic [15:0] accel;
	} drive_req_t;

	typedef struct packed {
		logic        pwm;
		logic [13:0] ch1;
		logic [13:0] ch2;
		logic [31:0] travelled;
		logic [31:0] mean;
	} drive_res_t;

	typedef struct {
		drive_req_t req;
		bit         typed;
		drive_res_t res;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// [15:0] encoder_count, [16] drive_enable, [48:17] move_distance,
	// [80:49] slowdown_distance, [112:81] cruise_velocity,
	// [144:113] final_velocity, [160:145] acceleration, rest zero
	logic [S_TDATA_W-1:0] s_tdata;
	// [0] action
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	// [13:0] channel_one_compare, [27:14] channel_two_compare,
	// [59:28] travelled_distance, [91:60] mean_velocity, rest zero
	logic [M_TDATA_W-1:0] m_tdata;
	// [0] pwm_update
	logic m_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// predictor copy of registers and drive state
	logic [GAIN_W-1:0] kp_gain = '0;
	logic [GAIN_W-1:0] kd_gain = '0;
	logic [GAIN_W-1:0] pulse_scale = DPP_RESET;
	longint odo_sum = 0;
	longint last_vel = 0;
	longint plan_vel = 0;
	longint target_vel = 0;
	longint target_dist = 0;
	longint brake_at = 0;
	longint brake_to = 0;
	longint unsigned ramp_accel = 0;
	bit slowdown_pending = 1'b0;
	longint err_hist [4] = '{0, 0, 0, 0};
	longint drive_acc = 0;

	drive_res_t drive_results_due [$];
	int bad_count = 0;
	int results_seen = 0;
	bit long_hold_done = 1'b0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;

	encoder_velocity_pid_motor_drive u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clip_value(longint v);
		if (v > VAL_MAX) return VAL_MAX;
		if (v < VAL_MIN) return VAL_MIN;
		return v;
	endfunction

	// a * g / 2^16 toward zero, split so the product never overflows
	function automatic longint scale_q16(longint a, logic [GAIN_W-1:0] g);
		bit neg;
		longint unsigned m, mh, ml, r, lim;
		neg = a < 0;
		m = neg ? -a : a;
		mh = m >> 24;
		ml = m & 64'hFF_FFFF;
		r = ((mh * g) << 8) + ((ml * g) >> 16);
		lim = VAL_MAX + (neg ? 1 : 0);
		if (r > lim) r = lim;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// advance the drive state by one request and return its result
	function automatic drive_res_t predict_drive(drive_req_t r);
		drive_res_t res;
		longint q, vel, mean, remain, step, p, d, combo, duty;
		res = '0;
		if (r.action == ACT_MOVE) begin
			target_dist = clip_value(longint'($signed(r.goal_dist)));
			brake_at = clip_value(longint'($signed(r.slow_dist)));
			target_vel = clip_value(longint'($signed(r.cruise_vel)));
			brake_to = clip_value(longint'($signed(r.final_vel)));
			ramp_accel = r.accel;
			slowdown_pending = 1'b1;
			res.travelled = 32'(clip_value(odo_sum));
			return res;
		end

		// odometry and two-sample velocity mean
		q = longint'(r.count);
		if (r.count > ENC_HALF) q = q - 65536;
		odo_sum = clip_value(odo_sum + scale_q16(q, pulse_scale));
		vel = scale_q16(q * VEL_SCALE, pulse_scale);
		mean = (vel + last_vel) / 2;
		last_vel = vel;

		// switch to the final velocity once inside the slowdown distance
		if (slowdown_pending) begin
			remain = target_dist - odo_sum;
			if (remain < 0) remain = -remain;
			if (brake_at >= remain) begin
				target_vel = brake_to;
				slowdown_pending = 1'b0;
			end
		end

		// ramp the planned velocity toward the target
		step = (longint'(ramp_accel) * 256) / 1000;
		if (target_vel > plan_vel) begin
			plan_vel = plan_vel + step;
			if (plan_vel > target_vel) plan_vel = target_vel;
		end else if (target_vel < plan_vel) begin
			plan_vel = plan_vel - step;
			if (plan_vel < target_vel) plan_vel = target_vel;
		end

		// velocity-form PD on the error history
		err_hist[3] = err_hist[2];
		err_hist[2] = err_hist[1];
		err_hist[1] = err_hist[0];
		err_hist[0] = clip_value(plan_vel - mean);
		p = scale_q16(err_hist[0], kp_gain);
		combo = (err_hist[0] - err_hist[3]) + 3 * (err_hist[1] - err_hist[2]);
		d = scale_q16(combo, kd_gain);
		drive_acc = clip_value(drive_acc + p + d);

		// clamp and split the drive over the two bridge channels
		if (r.enable) begin
			res.pwm = 1'b1;
			if (drive_acc > 0) begin
				if (drive_acc > DRIVE_LIMIT) drive_acc = DRIVE_LIMIT;
				duty = drive_acc >>> 8;
				res.ch1 = 14'(PWM_TOP - duty);
				res.ch2 = 14'(PWM_TOP);
			end else begin
				if (drive_acc < -DRIVE_LIMIT) drive_acc = -DRIVE_LIMIT;
				duty = (-drive_acc) >>> 8;
				res.ch1 = 14'(PWM_TOP);
				res.ch2 = 14'(PWM_TOP - duty);
			end
		end
		res.travelled = 32'(clip_value(odo_sum));
		res.mean = 32'(clip_value(mean));
		return res;
	endfunction

	function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			bad_count++;
			if (bad_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %0h, got %0h at %0t ns",
					what, want, got, $time);
		end
	endfunction

	function automatic drive_req_t tick_req(logic [15:0] count, logic en);
		return '{ACT_TICK, count, en, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0};
	endfunction

	function automatic drive_req_t move_req(logic [31:0] gd, logic [31:0] sd,
			logic [31:0] cv, logic [31:0] fv, logic [15:0] acc);
		return '{ACT_MOVE, 16'd0, 1'b0, gd, sd, cv, fv, acc};
	endfunction

	function automatic drive_req_t random_tick();
		drive_req_t r;
		r = '{ACT_TICK, 16'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
			$urandom, 16'($urandom)};
		if ($urandom_range(0, 7) != 0) r.count = 16'(int'($urandom_range(0, 400)) - 200);
		r.enable = ($urandom_range(0, 7) != 0);
		return r;
	endfunction

	function automatic drive_req_t random_move();
		drive_req_t r;
		r = '{ACT_MOVE, 16'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
			$urandom, 16'($urandom)};
		// mostly moves that finish within a run of ticks
		if ($urandom_range(0, 7) != 0) begin
			r.goal_dist = 32'(int'($urandom_range(0, 200000)) - 100000);
			r.slow_dist = 32'($urandom_range(0, 150000));
			r.cruise_vel = 32'(int'($urandom_range(0, 200000)) - 100000);
			r.final_vel = 32'(int'($urandom_range(0, 20000)) - 10000);
		end
		return r;
	endfunction

	// offer one request, hold it until taken, then queue its result
	task automatic send_request(input drive_req_t r, input bit typed, input drive_res_t typed_res);
		drive_res_t want;
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.action;
		s_tdata <= {7'd0, r.accel, r.final_vel, r.cruise_vel, r.slow_dist, r.goal_dist,
			r.enable, r.count};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = predict_drive(r);
		if (typed) want = typed_res;
		drive_results_due.push_back(want);
	endtask

	task automatic drain_results(input int settle);
		s_tvalid <= 1'b0;
		while (drive_results_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [1:0] idx,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_registers();
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, REG_KP, '0, rd);
		compare_field("proportional_gain", {8'd0, kp_gain}, rd);
		apb_access(1'b0, REG_KD, '0, rd);
		compare_field("derivative_gain", {8'd0, kd_gain}, rd);
		apb_access(1'b0, REG_DPP, '0, rd);
		compare_field("distance_per_pulse", {8'd0, pulse_scale}, rd);
	endtask

	// write all gains plus the unmapped slot, then read them back
	task automatic program_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
			input logic [GAIN_W-1:0] dpp);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, REG_KP, {8'($urandom), kp}, rd);
		kp_gain = kp;
		apb_access(1'b1, REG_KD, {8'($urandom), kd}, rd);
		kd_gain = kd;
		apb_access(1'b1, REG_DPP, {8'($urandom), dpp}, rd);
		pulse_scale = dpp;
		apb_access(1'b1, REG_SPARE, $urandom, rd);
		check_registers();
	endtask

	// check each result against the oldest pending one
	always @(posedge clk) begin
		drive_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[13:0], m_tdata[27:14], m_tdata[59:28], m_tdata[91:60]};
			results_seen++;
			if (drive_results_due.size() == 0) begin
				compare_field("unrequested result", '0, 32'd1);
			end else begin
				want = drive_results_due.pop_front();
				compare_field("pwm_update", want.pwm, got.pwm);
				compare_field("channel_one_compare", want.ch1, got.ch1);
				compare_field("channel_two_compare", want.ch2, got.ch2);
				compare_field("travelled_distance", want.travelled, got.travelled);
				compare_field("mean_velocity", want.mean, got.mean);
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back up the input
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("encoder_velocity_pid_motor_drive regression: fail");
		$finish;
	end

	initial begin
		plan_row_t plan [$];
		int sent;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_TICK;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_registers();

		// directed requests at reset gains; typed results only where obvious
		plan = '{
			// idle tick: zero drive lands on the channel two side with no duty
			'{tick_req(16'd0, 1'b1), 1'b1, '{1'b1, 14'd10000, 14'd10000, 32'd0, 32'd0}},
			// drive disabled: no compare update
			'{tick_req(16'd0, 1'b0), 1'b1, '{1'b0, 14'd0, 14'd0, 32'd0, 32'd0}},
			// move at field extremes, slowdown never reached
			'{move_req(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
				16'hffff), 1'b1, '{1'b0, 14'd0, 14'd0, 32'd0, 32'd0}},
			'{tick_req(16'd1, 1'b1), 1'b1, '{1'b1, 14'd10000, 14'd10000, 32'd1, 32'd696}},
			// top count reads as minus one
			'{tick_req(16'hffff, 1'b1), 1'b1, '{1'b1, 14'd10000, 14'd10000, 32'd0, 32'd0}},
			'{tick_req(16'h7fff, 1'b1), 1'b0, '0},
			'{tick_req(16'h8000, 1'b1), 1'b0, '0},
			'{tick_req(16'h8001, 1'b0), 1'b0, '0},
			'{tick_req(16'hffff, 1'b1), 1'b0, '0},
			// slowdown distance falls short of the remaining distance: no braking on the next tick
			'{move_req(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
				16'd0), 1'b0, '0},
			'{tick_req(16'd100, 1'b1), 1'b0, '0},
			'{tick_req(16'd0, 1'b1), 1'b0, '0},
			'{move_req(32'd0, 32'd0, 32'h0000_1000, 32'hffff_f000, 16'd1000), 1'b0, '0},
			'{tick_req(16'd0, 1'b1), 1'b0, '0},
			'{tick_req(16'd0, 1'b1), 1'b0, '0},
			'{tick_req(16'd0, 1'b1), 1'b0, '0},
			'{move_req(32'd100000, 32'd50000, 32'd25600, 32'd0, 16'd5000), 1'b0, '0},
			'{tick_req(16'd300, 1'b1), 1'b0, '0},
			'{tick_req(16'd300, 1'b1), 1'b0, '0},
			'{tick_req(16'd300, 1'b1), 1'b0, '0},
			'{tick_req(16'd300, 1'b1), 1'b0, '0},
			'{tick_req(16'h7fff, 1'b0), 1'b0, '0}
		};
		foreach (plan[i])
			send_request(plan[i].req, plan[i].typed, plan[i].res);

		// random phases, each programming its gains and setting an idling pattern
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results(8);
			case (phase)
				0: begin
					sender_idles = 1'b1;
					receiver_idles = 1'b1;
					program_gains(24'h01_0000, 24'h00_4000, DPP_RESET);
				end
				1: begin
					sender_idles = 1'b1;
					receiver_idles = 1'b0;
					program_gains(24'hff_ffff, 24'hff_ffff, 24'hff_ffff);
				end
				2: begin
					sender_idles = 1'b0;
					receiver_idles = 1'b1;
					program_gains(24'd0, 24'd0, 24'd0);
				end
				3: begin
					sender_idles = 1'b0;
					receiver_idles = 1'b0;
					program_gains(24'($urandom), 24'($urandom), 24'($urandom));
				end
				4: begin
					sender_idles = 1'b1;
					receiver_idles = 1'b1;
					program_gains(24'($urandom_range(0, 24'h03_0000)),
						24'($urandom_range(0, 24'h01_0000)), 24'($urandom));
				end
				default: begin
					sender_idles = 1'b0;
					receiver_idles = 1'b0;
					program_gains(24'h00_0100, 24'd0, 24'($urandom));
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: any action, any field contents
					send_request(drive_req_t'({$urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom}), 1'b0, '0);
					sent++;
				end else begin
					send_request(random_move(), 1'b0, '0);
					sent++;
					repeat ($urandom_range(4, 40)) begin
						send_request(random_tick(), 1'b0, '0);
						sent++;
					end
				end
			end
		end

		drain_results(DRAIN_CYCLES);
		if (bad_count == 0)
			$display("encoder_velocity_pid_motor_drive regression: pass");
		else
			$display("encoder_velocity_pid_motor_drive regression: fail");
		$finish;
	end

endmodule
